// File: design/wavhp_pkg.sv
// shared types and constants of the wave header parser
`timescale 1ns / 1ps
`default_nettype none

package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam int unsigned MIN_FILE    = 44;
  localparam int unsigned FMT_MIN     = 16;
  localparam int unsigned FIRST_CHUNK = 12;
  localparam int unsigned RIFF_END    = 3;
  localparam int unsigned WAVE_END    = 11;

  // byte offsets inside a fmt body where a field completes
  localparam int unsigned FMT_OFF_CODE_LO = 0;
  localparam int unsigned FMT_OFF_CODE_HI = 1;
  localparam int unsigned FMT_OFF_CH_END  = 3;
  localparam int unsigned FMT_OFF_RATE_END = 7;
  localparam int unsigned FMT_OFF_BITS_END = 15;
  localparam logic [15:0] FMT_CODE_PCM = 16'd1;
  localparam logic [15:0] BITS_16      = 16'd16;

  // header end position is next_header_at + 7, kept in 34 bits
  localparam int unsigned HDR_W = 34;
  localparam logic [HDR_W-1:0] HDR_END_RST = HDR_W'(FIRST_CHUNK + 7);
  localparam logic [HDR_W-1:0] NEXT_CLAMP  = 34'h1_FFFF_FFFF;
  localparam logic [HDR_W-1:0] HDR_TAIL    = 34'd7;

  localparam int unsigned OUT_W = 168;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NOT_RIFF = 3'd2,
    ST_NOT_WAVE = 3'd3,
    ST_NOT_PCM  = 3'd4,
    ST_NO_DATA  = 3'd5,
    ST_ZERO_CH  = 3'd6,
    ST_BAD_BITS = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef struct packed {
    logic        header_ok;
    status_t     status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] pcm_offset;
    logic [31:0] pcm_bytes;
    logic [30:0] sample_total;
  } result_t;

endpackage

`default_nettype wire

// File: design/wavhp_parser.sv
// chunk walker and field latches, one file byte per request
`timescale 1ns / 1ps
`default_nettype none

module wavhp_parser #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [7:0]          file_byte,
  input  wire logic                end_of_file,
  output wavhp_pkg::result_t       res
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned HW = wavhp_pkg::HDR_W;

  logic [PB-1:0]        pos_r, pos_nxt;
  logic [31:0]          tag_r, tag_nxt;
  logic [HW-1:0]        hdr_end_r, hdr_end_nxt;
  logic [63:0]          hcol_r, hcol_nxt;
  wavhp_pkg::kind_t     kind_r, kind_nxt;
  logic [PB-1:0]        body_at_r, body_at_nxt;
  logic [15:0]          fmt_ch_r, fmt_ch_nxt;
  logic [31:0]          fmt_rate_r, fmt_rate_nxt;
  logic [15:0]          fmt_bits_r, fmt_bits_nxt;
  logic [7:0]           code_lo_r, code_lo_nxt;
  logic                 found_r, found_nxt;
  logic [31:0]          dstart_r, dstart_nxt;
  logic [31:0]          dlen_r, dlen_nxt;
  wavhp_pkg::status_t   err_r, err_nxt;

  always_comb begin
    logic [PB-1:0]   p;
    logic [PB-1:0]   off;
    logic [PB-1:0]   body;
    logic [31:0]     tag_new;
    logic [31:0]     size;
    logic [31:0]     id;
    logic [HW-1:0]   padded;
    logic [HW-1:0]   next;
    logic            stop;
    wavhp_pkg::status_t st;

    pos_nxt      = pos_r;
    tag_nxt      = tag_r;
    hdr_end_nxt  = hdr_end_r;
    hcol_nxt     = hcol_r;
    kind_nxt     = kind_r;
    body_at_nxt  = body_at_r;
    fmt_ch_nxt   = fmt_ch_r;
    fmt_rate_nxt = fmt_rate_r;
    fmt_bits_nxt = fmt_bits_r;
    code_lo_nxt  = code_lo_r;
    found_nxt    = found_r;
    dstart_nxt   = dstart_r;
    dlen_nxt     = dlen_r;
    err_nxt      = err_r;

    p       = pos_r;
    off     = pos_r - body_at_r;
    body    = pos_r + PB'(1);
    tag_new = {tag_r[23:0], file_byte};
    size    = {file_byte, hcol_r[7:0], hcol_r[15:8], hcol_r[23:16]};
    id      = hcol_r[55:24];
    padded  = (HW'(size) + HW'(1)) & ~HW'(1);
    next    = HW'(body) + padded;
    stop    = 1'b0;

    // a saturated position count parses nothing more
    if (pos_r != '1) begin
      pos_nxt  = body;
      hcol_nxt = {hcol_r[55:0], file_byte};
      if (p < PB'(wavhp_pkg::FIRST_CHUNK)) begin
        tag_nxt = tag_new;
        if (p == PB'(wavhp_pkg::RIFF_END) && tag_new != wavhp_pkg::TAG_RIFF) begin
          err_nxt = wavhp_pkg::ST_NOT_RIFF;
        end
        if (p == PB'(wavhp_pkg::WAVE_END) && tag_new != wavhp_pkg::TAG_WAVE &&
            err_r == wavhp_pkg::ST_OK) begin
          err_nxt = wavhp_pkg::ST_NOT_WAVE;
        end
      end else if (err_r == wavhp_pkg::ST_OK) begin
        if (kind_r == wavhp_pkg::KIND_FMT && p >= body_at_r &&
            off < PB'(wavhp_pkg::FMT_MIN)) begin
          if (off == PB'(wavhp_pkg::FMT_OFF_CODE_LO)) begin
            code_lo_nxt = file_byte;
          end else if (off == PB'(wavhp_pkg::FMT_OFF_CODE_HI)) begin
            if ({file_byte, code_lo_r} != wavhp_pkg::FMT_CODE_PCM) begin
              err_nxt = wavhp_pkg::ST_NOT_PCM;
              stop    = 1'b1;
            end
          end else if (off == PB'(wavhp_pkg::FMT_OFF_CH_END)) begin
            fmt_ch_nxt = {file_byte, hcol_r[7:0]};
          end else if (off == PB'(wavhp_pkg::FMT_OFF_RATE_END)) begin
            fmt_rate_nxt = size;
          end else if (off == PB'(wavhp_pkg::FMT_OFF_BITS_END)) begin
            fmt_bits_nxt = {file_byte, hcol_r[7:0]};
          end
        end
        // last byte of a chunk header
        if (!stop && HW'(p) == hdr_end_r) begin
          body_at_nxt = body;
          kind_nxt    = wavhp_pkg::KIND_OTHER;
          if (id == wavhp_pkg::TAG_FMT && size >= 32'(wavhp_pkg::FMT_MIN)) begin
            kind_nxt = wavhp_pkg::KIND_FMT;
          end else if (id == wavhp_pkg::TAG_DATA) begin
            kind_nxt   = wavhp_pkg::KIND_DATA;
            found_nxt  = 1'b1;
            dstart_nxt = 32'(body);
            dlen_nxt   = size;
          end
          if (next > wavhp_pkg::NEXT_CLAMP) begin
            hdr_end_nxt = wavhp_pkg::NEXT_CLAMP + wavhp_pkg::HDR_TAIL;
          end else begin
            hdr_end_nxt = next + wavhp_pkg::HDR_TAIL;
          end
        end
      end
    end

    if (pos_nxt < PB'(wavhp_pkg::MIN_FILE)) begin
      st = wavhp_pkg::ST_SHORT;
    end else if (err_nxt != wavhp_pkg::ST_OK) begin
      st = err_nxt;
    end else if (!found_nxt) begin
      st = wavhp_pkg::ST_NO_DATA;
    end else if (fmt_ch_nxt == 16'd0) begin
      st = wavhp_pkg::ST_ZERO_CH;
    end else if (fmt_bits_nxt != wavhp_pkg::BITS_16) begin
      st = wavhp_pkg::ST_BAD_BITS;
    end else begin
      st = wavhp_pkg::ST_OK;
    end

    res.header_ok     = (st == wavhp_pkg::ST_OK);
    res.status        = st;
    res.channel_count = fmt_ch_nxt;
    res.rate_hz       = fmt_rate_nxt;
    res.sample_bits   = fmt_bits_nxt;
    res.pcm_offset    = dstart_nxt;
    res.pcm_bytes     = dlen_nxt;
    res.sample_total  = dlen_nxt[31:1];
  end

  // the final byte of a file returns everything to the reset state
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && end_of_file)) begin
      pos_r      <= '0;
      tag_r      <= '0;
      hdr_end_r  <= wavhp_pkg::HDR_END_RST;
      hcol_r     <= '0;
      kind_r     <= wavhp_pkg::KIND_OTHER;
      body_at_r  <= '0;
      fmt_ch_r   <= '0;
      fmt_rate_r <= '0;
      fmt_bits_r <= '0;
      code_lo_r  <= '0;
      found_r    <= 1'b0;
      dstart_r   <= '0;
      dlen_r     <= '0;
      err_r      <= wavhp_pkg::ST_OK;
    end else if (acc) begin
      pos_r      <= pos_nxt;
      tag_r      <= tag_nxt;
      hdr_end_r  <= hdr_end_nxt;
      hcol_r     <= hcol_nxt;
      kind_r     <= kind_nxt;
      body_at_r  <= body_at_nxt;
      fmt_ch_r   <= fmt_ch_nxt;
      fmt_rate_r <= fmt_rate_nxt;
      fmt_bits_r <= fmt_bits_nxt;
      code_lo_r  <= code_lo_nxt;
      found_r    <= found_nxt;
      dstart_r   <= dstart_nxt;
      dlen_r     <= dlen_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/wavhp_out_buf.sv
// two-entry result register with skid slot
`timescale 1ns / 1ps
`default_nettype none

module wavhp_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wavhp_pkg::result_t      res,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wavhp_pkg::result_t      out_res
);

  wavhp_pkg::result_t main_r, main_nxt;
  wavhp_pkg::result_t skid_r, skid_nxt;
  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  logic               pop;

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;
  assign pop       = main_v_r && out_ready;

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = res;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

// File: design/wav_header_parser_top.sv
// wave header parser: byte stream in, one header summary out per file
//
// in channel: one file byte per request, in_tlast on the final byte of a file.
// out channel: one summary per file, issued for the request that carries
// in_tlast; bytes without in_tlast produce nothing on the output.
// throughput is one byte per clock while in_tready is high: every byte is
// compared and latched by the parser in the cycle it is taken, the only wide
// path being the 34-bit add and compare that locates the next chunk header.
// the summary is registered in the result buffer and shown on out_tvalid.
// the parser restarts from its reset state right after the final byte, so the
// next file may follow in the next cycle.
// when the receiver stalls, a second summary is held in a skid slot; in_tready
// drops only while both result slots are occupied.
// reset (rst_n low, synchronous) clears the parser state and empties the
// result slots.
// byte positions saturate at 2**POSITION_BITS - 1; later bytes are not parsed.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser_top #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // file_byte[7:0]
  input  wire logic        in_tlast,   // end_of_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // header_ok[0], status[3:1], channel_count[19:4], rate_hz[51:20],
  // sample_bits[67:52], pcm_offset[99:68], pcm_bytes[131:100],
  // sample_total[162:132], zero pad[167:163]
  output logic [wavhp_pkg::OUT_W-1:0] out_tdata
);

  logic               acc;
  wavhp_pkg::result_t parse_res;
  wavhp_pkg::result_t out_res;

  assign acc = in_tvalid && in_tready;

  wavhp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .file_byte  (in_tdata),
    .end_of_file(in_tlast),
    .res        (parse_res)
  );

  wavhp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc && in_tlast),
    .res      (parse_res),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {5'd0,
                      out_res.sample_total,
                      out_res.pcm_bytes,
                      out_res.pcm_offset,
                      out_res.sample_bits,
                      out_res.rate_hz,
                      out_res.channel_count,
                      out_res.status,
                      out_res.header_ok};

`ifndef ASSERT_OFF
  // input only blocks when a summary is already waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // a final byte always leaves a result pending on the output in the next cycle
  a_eof_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("final byte produced no result");

  // ok flag agrees with status
  a_ok_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == wavhp_pkg::ST_OK)))
    else $error("header_ok disagrees with status");

  // sample count is half the byte count
  a_sample_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[162:132] == out_tdata[131:101]))
    else $error("sample_total mismatch");
`endif

endmodule

`default_nettype wire
